// ===== hdl/hvmu_pkg.sv =====
// ----------------------------------------------------------------------------
// hvmu_pkg
// Shared constants and types for the HMM max-product metric update core.
// ----------------------------------------------------------------------------
package hvmu_pkg;

  localparam int NumStates = 16;
  localparam int StW       = 4;
  localparam int ProbW     = 17;
  localparam int FracBits  = 16;
  localparam logic [ProbW-1:0] ProbOne = 17'h10000;

  localparam logic [2:0] CMD_LOAD_INIT  = 3'd0;
  localparam logic [2:0] CMD_LOAD_TRANS = 3'd1;
  localparam logic [2:0] CMD_LOAD_EMIS  = 3'd2;
  localparam logic [2:0] CMD_START      = 3'd3;
  localparam logic [2:0] CMD_NEXT       = 3'd4;

  localparam logic [2:0] OP_HOLD       = 3'd0;
  localparam logic [2:0] OP_DIV_FIRST  = 3'd1;
  localparam logic [2:0] OP_DIV_STEP   = 3'd2;
  localparam logic [2:0] OP_DIV_DONE   = 3'd3;
  localparam logic [2:0] OP_MUL_ROT    = 3'd4;
  localparam logic [2:0] OP_EMIT_START = 3'd5;
  localparam logic [2:0] OP_EMIT_NEXT  = 3'd6;
  localparam logic [2:0] OP_ROT        = 3'd7;

  typedef struct packed {
    logic [2:0]       op;
    logic             acc;
    logic [StW-1:0]   k;
    logic [StW-1:0]   sym;
    logic [StW:0]     n;
    logic [ProbW-1:0] peak;
  } cell_ctrl_t;

  typedef struct packed {
    logic             we_init;
    logic             we_trans;
    logic             we_emis;
    logic [StW-1:0]   row;
    logic [StW-1:0]   col;
    logic [ProbW-1:0] val;
  } cell_load_t;

endpackage

// ===== hdl/hvmu_cell.sv =====
// ----------------------------------------------------------------------------
// hvmu_cell
// One state of the ring: holds its metric, transition column, emission row
// and initial value; divides, multiplies and maxes its own metric.
// ----------------------------------------------------------------------------
module hvmu_cell (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [hvmu_pkg::StW-1:0]    idx_i,
  input  hvmu_pkg::cell_ctrl_t        ctrl_i,
  input  hvmu_pkg::cell_load_t        load_i,
  input  logic [hvmu_pkg::ProbW-1:0]  pm_nb_i,
  output logic [hvmu_pkg::ProbW-1:0]  pm_o
);

  logic [hvmu_pkg::ProbW-1:0] init_q;
  logic [hvmu_pkg::ProbW-1:0] trans_q [hvmu_pkg::NumStates];
  logic [hvmu_pkg::ProbW-1:0] emis_q  [hvmu_pkg::NumStates];
  logic [hvmu_pkg::ProbW-1:0] pm_q, pm_d;
  logic [hvmu_pkg::ProbW-1:0] mx_q, pr_q, r_q, q_q;

  logic [hvmu_pkg::StW-1:0]     src;
  logic                         src_ok, act;
  logic [hvmu_pkg::ProbW-1:0]   mul_a, mul_b, prod_s;
  logic [2*hvmu_pkg::ProbW-1:0] prod;
  logic [hvmu_pkg::ProbW:0]     t, diff;
  logic                         ge;

  assign src    = idx_i + ctrl_i.k;
  assign src_ok = {1'b0, src} < ctrl_i.n;
  assign act    = {1'b0, idx_i} < ctrl_i.n;

  always_comb begin
    case (ctrl_i.op)
      hvmu_pkg::OP_MUL_ROT: begin
        mul_a = pm_q;
        mul_b = trans_q[src];
      end
      hvmu_pkg::OP_EMIT_NEXT: begin
        mul_a = mx_q;
        mul_b = emis_q[ctrl_i.sym];
      end
      default: begin
        mul_a = init_q;
        mul_b = emis_q[ctrl_i.sym];
      end
    endcase
  end

  assign prod   = {{hvmu_pkg::ProbW{1'b0}}, mul_a} * {{hvmu_pkg::ProbW{1'b0}}, mul_b};
  assign prod_s = prod[hvmu_pkg::FracBits +: hvmu_pkg::ProbW];

  assign t    = (ctrl_i.op == hvmu_pkg::OP_DIV_FIRST) ? {1'b0, pm_q} : {r_q, 1'b0};
  assign ge   = t >= {1'b0, ctrl_i.peak};
  assign diff = t - {1'b0, ctrl_i.peak};

  always_comb begin
    pm_d = pm_q;
    case (ctrl_i.op)
      hvmu_pkg::OP_DIV_DONE:   pm_d = q_q;
      hvmu_pkg::OP_MUL_ROT:    pm_d = pm_nb_i;
      hvmu_pkg::OP_ROT:        pm_d = pm_nb_i;
      hvmu_pkg::OP_EMIT_START: pm_d = act ? prod_s : '0;
      hvmu_pkg::OP_EMIT_NEXT:  pm_d = act ? prod_s : '0;
      default:                 pm_d = pm_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pm_q <= '0;
    end else begin
      pm_q <= pm_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i.we_init && load_i.row == idx_i) begin
      init_q <= load_i.val;
    end
    if (load_i.we_trans && load_i.col == idx_i) begin
      trans_q[load_i.row] <= load_i.val;
    end
    if (load_i.we_emis && load_i.row == idx_i) begin
      emis_q[load_i.col] <= load_i.val;
    end
    if (ctrl_i.op == hvmu_pkg::OP_DIV_FIRST || ctrl_i.op == hvmu_pkg::OP_DIV_STEP) begin
      r_q <= ge ? diff[hvmu_pkg::ProbW-1:0] : t[hvmu_pkg::ProbW-1:0];
      q_q <= (ctrl_i.op == hvmu_pkg::OP_DIV_FIRST) ? {{(hvmu_pkg::ProbW-1){1'b0}}, ge}
                                                  : {q_q[hvmu_pkg::ProbW-2:0], ge};
    end
    if (ctrl_i.op == hvmu_pkg::OP_MUL_ROT) begin
      pr_q <= src_ok ? prod_s : '0;
    end
    if (ctrl_i.op == hvmu_pkg::OP_MUL_ROT && ctrl_i.k == '0) begin
      mx_q <= '0;
    end else if (ctrl_i.acc && pr_q > mx_q) begin
      mx_q <= pr_q;
    end
  end

  assign pm_o = pm_q;

endmodule

// ===== hdl/hmm_viterbi_metric_update_core.sv =====
// ----------------------------------------------------------------------------
// hmm_viterbi_metric_update_core
// Max-product HMM decoder step built as a ring of sixteen state cells.
// ----------------------------------------------------------------------------
// Requests enter on start with cmd, row_index, col_index, prob_value and
// symbol, taken when start is high and busy is low.
// Load requests (initial, transition, emission) are written at the accepting
// edge; they give no result.
// A start observation raises done_o after the emission product and a ring
// scan for the best state. A next observation first runs a bit-serial
// divide per cell by the previous peak and a write-back step (both skipped
// when that peak is zero), then ring rotations of metric times transition
// with a running maximum, a step to fold the last product, the emission
// product and the ring scan.
// busy stays high through the done cycle; the next request is taken after it.
// The result is on best_state_o, best_metric_o and all_zero_o while done_o
// is high and holds until the next emission step; the receiver cannot stall it.
// states_in_use is written on the APB port at byte addresses 0 to 3.
// Reset clears metrics, peak and control; tables are undefined until loaded.
// ----------------------------------------------------------------------------
module hmm_viterbi_metric_update_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [2:0]                  cmd_i,
  input  logic [3:0]                  row_index_i,
  input  logic [3:0]                  col_index_i,
  input  logic [16:0]                 prob_value_i,
  input  logic [3:0]                  symbol_i,
  output logic                        done_o,
  output logic [3:0]                  best_state_o,
  output logic [16:0]                 best_metric_o,
  output logic                        all_zero_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [2:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_DIVD = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_ACC  = 3'd4;
  localparam logic [2:0] S_EMIT = 3'd5;
  localparam logic [2:0] S_SCAN = 3'd6;
  localparam logic [2:0] S_DONE = 3'd7;

  logic [2:0]  state_q, state_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [4:0]  siu_q;
  logic [3:0]  sym_q;
  logic        first_q;
  logic [16:0] peak_q, bestm_q;
  logic [3:0]  best_q;
  logic [4:0]  n_sat;
  logic        accept;
  logic        cfg_we;

  hvmu_pkg::cell_ctrl_t ctrl;
  hvmu_pkg::cell_load_t load;
  logic [16:0] pm_w [hvmu_pkg::NumStates];

  assign accept = start && !busy;
  assign busy   = state_q != S_IDLE;
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && !paddr[2];
  assign prdata = paddr[2] ? 32'd0 : {27'd0, siu_q};

  always_comb begin
    if (siu_q == 5'd0) begin
      n_sat = 5'd1;
    end else if (siu_q > 5'd16) begin
      n_sat = 5'd16;
    end else begin
      n_sat = siu_q;
    end
  end

  assign load.we_init  = accept && cmd_i == hvmu_pkg::CMD_LOAD_INIT;
  assign load.we_trans = accept && cmd_i == hvmu_pkg::CMD_LOAD_TRANS;
  assign load.we_emis  = accept && cmd_i == hvmu_pkg::CMD_LOAD_EMIS;
  assign load.row      = row_index_i;
  assign load.col      = col_index_i;
  assign load.val      = prob_value_i[16] ? hvmu_pkg::ProbOne : prob_value_i;

  always_comb begin
    ctrl.op   = hvmu_pkg::OP_HOLD;
    ctrl.acc  = 1'b0;
    ctrl.k    = cnt_q[3:0];
    ctrl.sym  = sym_q;
    ctrl.n    = n_sat;
    ctrl.peak = peak_q;
    state_d   = state_q;
    cnt_d     = cnt_q;
    case (state_q)
      S_IDLE: begin
        cnt_d = 5'd0;
        if (accept && cmd_i == hvmu_pkg::CMD_START) begin
          state_d = S_EMIT;
        end else if (accept && cmd_i == hvmu_pkg::CMD_NEXT) begin
          state_d = (peak_q != 17'd0) ? S_DIV : S_MUL;
        end
      end
      S_DIV: begin
        ctrl.op = (cnt_q == 5'd0) ? hvmu_pkg::OP_DIV_FIRST : hvmu_pkg::OP_DIV_STEP;
        cnt_d   = cnt_q + 5'd1;
        if (cnt_q == 5'd16) begin
          state_d = S_DIVD;
        end
      end
      S_DIVD: begin
        ctrl.op = hvmu_pkg::OP_DIV_DONE;
        cnt_d   = 5'd0;
        state_d = S_MUL;
      end
      S_MUL: begin
        ctrl.op  = hvmu_pkg::OP_MUL_ROT;
        ctrl.acc = cnt_q != 5'd0;
        cnt_d    = cnt_q + 5'd1;
        if (cnt_q == 5'd15) begin
          state_d = S_ACC;
        end
      end
      S_ACC: begin
        ctrl.acc = 1'b1;
        state_d  = S_EMIT;
      end
      S_EMIT: begin
        ctrl.op = first_q ? hvmu_pkg::OP_EMIT_START : hvmu_pkg::OP_EMIT_NEXT;
        cnt_d   = 5'd0;
        state_d = S_SCAN;
      end
      S_SCAN: begin
        ctrl.op = hvmu_pkg::OP_ROT;
        cnt_d   = cnt_q + 5'd1;
        if (cnt_q == 5'd15) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= 5'd0;
      siu_q   <= 5'd16;
      peak_q  <= 17'd0;
      first_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (cfg_we) begin
        siu_q <= pwdata[4:0];
      end
      if (accept) begin
        first_q <= cmd_i == hvmu_pkg::CMD_START;
      end
      if (state_q == S_DONE) begin
        peak_q <= bestm_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      sym_q <= symbol_i;
    end
    if (state_q == S_EMIT) begin
      bestm_q <= 17'd0;
      best_q  <= 4'd0;
    end else if (state_q == S_SCAN && pm_w[0] > bestm_q) begin
      bestm_q <= pm_w[0];
      best_q  <= cnt_q[3:0];
    end
  end

  for (genvar g = 0; g < hvmu_pkg::NumStates; g++) begin : g_cell
    hvmu_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .idx_i   (4'(g)),
      .ctrl_i  (ctrl),
      .load_i  (load),
      .pm_nb_i (pm_w[(g + 1) % hvmu_pkg::NumStates]),
      .pm_o    (pm_w[g])
    );
  end

  assign done_o        = state_q == S_DONE;
  assign best_state_o  = best_q;
  assign best_metric_o = bestm_q;
  assign all_zero_o    = bestm_q == 17'd0;

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives table loads, start and next observations and states_in_use writes
// into hmm_viterbi_metric_update_core. A scoreboard predicts the best state,
// best metric and all-zero flag of each observation and checks every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  localparam logic [2:0] CmdSpareFirst = 3'd5;
  localparam logic [2:0] CmdSpareLast  = 3'd7;
  localparam logic [2:0] AddrStates    = 3'd0;
  localparam int         StallLimit    = 5000;
  localparam int         DrainCycles   = 80;

  class viterbi_scoreboard;
    longint unsigned init_p [16];
    longint unsigned trans_p [256];
    longint unsigned emis_p [256];
    longint unsigned metric [16];
    longint unsigned peak;
    int unsigned     states_reg;
    logic [3:0]      exp_state [$];
    logic [16:0]     exp_metric [$];
    logic            exp_zero [$];
    int unsigned     errors;

    function new();
      states_reg = 16;
      peak = 0;
      errors = 0;
      foreach (metric[k]) metric[k] = 0;
      foreach (init_p[k]) init_p[k] = 0;
      foreach (trans_p[k]) trans_p[k] = 0;
      foreach (emis_p[k]) emis_p[k] = 0;
    endfunction

    task report(string what, longint unsigned got, longint unsigned want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      errors++;
    endtask

    function void note(logic [2:0] cmd, logic [3:0] row, logic [3:0] col,
                       logic [16:0] val, logic [3:0] sym);
      longint unsigned v, fresh [16], m, p, best_v;
      int unsigned n, best;
      v = (val > hvmu_pkg::ProbOne) ? hvmu_pkg::ProbOne : val;
      n = (states_reg < 1) ? 1 : (states_reg > 16 ? 16 : states_reg);
      case (cmd)
        hvmu_pkg::CMD_LOAD_INIT:  init_p[row] = v;
        hvmu_pkg::CMD_LOAD_TRANS: trans_p[row*16+col] = v;
        hvmu_pkg::CMD_LOAD_EMIS:  emis_p[row*16+col] = v;
        hvmu_pkg::CMD_START, hvmu_pkg::CMD_NEXT: begin
          foreach (fresh[k]) fresh[k] = 0;
          if (cmd == hvmu_pkg::CMD_START) begin
            for (int j = 0; j < n; j++)
              fresh[j] = (init_p[j] * emis_p[j*16+sym]) >> hvmu_pkg::FracBits;
          end else begin
            if (peak != 0)
              for (int i = 0; i < n; i++)
                metric[i] = (metric[i] << hvmu_pkg::FracBits) / peak;
            for (int j = 0; j < n; j++) begin
              m = 0;
              for (int i = 0; i < n; i++) begin
                p = (metric[i] * trans_p[i*16+j]) >> hvmu_pkg::FracBits;
                if (p > m) m = p;
              end
              fresh[j] = (m * emis_p[j*16+sym]) >> hvmu_pkg::FracBits;
            end
          end
          best_v = 0;
          best = 0;
          for (int j = 0; j < n; j++)
            if (fresh[j] > best_v) begin
              best_v = fresh[j];
              best = j;
            end
          metric = fresh;
          peak = best_v;
          exp_state.push_back(best[3:0]);
          exp_metric.push_back(best_v[16:0]);
          exp_zero.push_back(best_v == 0);
        end
        default: ;
      endcase
    endfunction

    task check(logic [3:0] bs, logic [16:0] bm, logic az);
      if (exp_state.size() == 0) begin
        report("unexpected result", bs, 0);
      end else begin
        if (bs !== exp_state[0]) report("best_state", bs, exp_state[0]);
        if (bm !== exp_metric[0]) report("best_metric", bm, exp_metric[0]);
        if (az !== exp_zero[0]) report("all_zero", az, exp_zero[0]);
        void'(exp_state.pop_front());
        void'(exp_metric.pop_front());
        void'(exp_zero.pop_front());
      end
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  cmd_i = '0;
  logic [3:0]  row_index_i = '0;
  logic [3:0]  col_index_i = '0;
  logic [16:0] prob_value_i = '0;
  logic [3:0]  symbol_i = '0;
  logic        done_o;
  logic [3:0]  best_state_o;
  logic [16:0] best_metric_o;
  logic        all_zero_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  viterbi_scoreboard sb = new();
  int unsigned       stall_cycles = 0;
  int unsigned       idle_pct = 0;

  always #5 clk_i = ~clk_i;

  hmm_viterbi_metric_update_core u_dut (
    .clk_i, .rst_ni, .start, .busy, .cmd_i, .row_index_i, .col_index_i,
    .prob_value_i, .symbol_i, .done_o, .best_state_o, .best_metric_o,
    .all_zero_o, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      sb.check(best_state_o, best_metric_o, all_zero_o);
      stall_cycles <= 0;
    end else if (rst_ni && start && !busy) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles > StallLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  task send_request(logic [2:0] cmd, logic [3:0] row, logic [3:0] col,
                    logic [16:0] val, logic [3:0] sym);
    start <= 1'b1;
    cmd_i <= cmd;
    row_index_i <= row;
    col_index_i <= col;
    prob_value_i <= val;
    symbol_i <= sym;
    do @(posedge clk_i); while (busy);
    sb.note(cmd, row, col, val, sym);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
  endtask

  task drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (sb.exp_state.size() != 0 || busy) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task write_states(logic [4:0] value);
    drain();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= AddrStates;
    pwdata <= {27'd0, value};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.states_reg = value;
    @(posedge clk_i);
  endtask

  function automatic logic [16:0] rand_prob();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 8) return '0;
    if (r < 16) return hvmu_pkg::ProbOne;
    if (r < 22) return 17'($urandom_range(65537, 131071));
    return 17'($urandom_range(1, 65535));
  endfunction

  task random_request();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 12)
      send_request(hvmu_pkg::CMD_LOAD_INIT, 4'($urandom), 4'($urandom), rand_prob(),
                   4'($urandom));
    else if (r < 24)
      send_request(hvmu_pkg::CMD_LOAD_TRANS, 4'($urandom), 4'($urandom), rand_prob(),
                   4'($urandom));
    else if (r < 36)
      send_request(hvmu_pkg::CMD_LOAD_EMIS, 4'($urandom), 4'($urandom), rand_prob(),
                   4'($urandom));
    else if (r < 50)
      send_request(hvmu_pkg::CMD_START, 4'($urandom), 4'($urandom), 17'($urandom),
                   4'($urandom));
    else if (r < 95)
      send_request(hvmu_pkg::CMD_NEXT, 4'($urandom), 4'($urandom), 17'($urandom),
                   4'($urandom));
    else
      send_request(3'($urandom_range(CmdSpareFirst, CmdSpareLast)), 4'($urandom),
                   4'($urandom), 17'($urandom), 4'($urandom));
  endtask

  initial begin
    logic [4:0] seg_states [5];
    seg_states = '{5'd1, 5'd16, 5'd0, 5'd31, 5'($urandom_range(2, 15))};
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // fill every table entry so no observation reads an unwritten one
    for (int s = 0; s < 16; s++) begin
      send_request(hvmu_pkg::CMD_LOAD_INIT, 4'(s), 4'(s), rand_prob(), 4'(s));
      for (int c = 0; c < 16; c++) begin
        send_request(hvmu_pkg::CMD_LOAD_TRANS, 4'(s), 4'(c), rand_prob(), 4'(c));
        send_request(hvmu_pkg::CMD_LOAD_EMIS, 4'(s), 4'(c),
                     (c == 15) ? 17'd0 : rand_prob(), 4'(c));
      end
    end

    // next before any start, then zero peak, then extremes and spare codes
    send_request(hvmu_pkg::CMD_NEXT, 4'd0, 4'd0, 17'd0, 4'd3);
    send_request(hvmu_pkg::CMD_START, 4'd0, 4'd0, 17'd0, 4'd15);
    send_request(hvmu_pkg::CMD_NEXT, 4'd0, 4'd0, 17'd0, 4'd2);
    send_request(hvmu_pkg::CMD_LOAD_INIT, 4'd15, 4'd15, 17'h1FFFF, 4'd15);
    send_request(hvmu_pkg::CMD_LOAD_EMIS, 4'd15, 4'd0, 17'h10000, 4'd0);
    send_request(hvmu_pkg::CMD_LOAD_TRANS, 4'd15, 4'd15, 17'h10000, 4'd0);
    send_request(hvmu_pkg::CMD_LOAD_INIT, 4'd0, 4'd0, 17'h0FFFF, 4'd0);
    send_request(hvmu_pkg::CMD_START, 4'hF, 4'hF, 17'h1FFFF, 4'd0);
    send_request(hvmu_pkg::CMD_NEXT, 4'hF, 4'hF, 17'h1FFFF, 4'd1);
    send_request(hvmu_pkg::CMD_NEXT, 4'd0, 4'd0, 17'd0, 4'd0);
    send_request(CmdSpareFirst, 4'd1, 4'd1, 17'd1, 4'd1);
    send_request(3'd6, 4'd2, 4'd2, 17'd2, 4'd2);
    send_request(CmdSpareLast, 4'hF, 4'hF, 17'h1FFFF, 4'hF);

    for (int seg = 0; seg < 5; seg++) begin
      write_states(seg_states[seg]);
      idle_pct = (seg < 2) ? 36 : (seg < 4) ? 47 : 0;
      for (int k = 0; k < 22; k++) begin
        random_request();
      end
    end

    drain();
    if (sb.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
